>>> src/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window median filter
// Sizes of the sorted cell row, sample type and neighbor beat between cells.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int WINDOW_MAX  = 32;
	localparam int SAMPLE_BITS = 16;

	localparam int IDX_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int AGE_W     = IDX_W;
	localparam int CNT_W     = $clog2(WINDOW_MAX + 1);
	localparam int LEN_REG_W = 6;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic REG_WINDOW_LEN = 1'b0;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [AGE_W-1:0]              age_t;

	typedef struct packed {
		sample_t val;
		age_t    age;
		logic    gt;
	} nb_t;

endpackage

>>> src/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted window row
// Holds one sample with its age; on each beat removes the oldest entry and
// inserts the new sample by taking from itself, a neighbor or the input.
// ----------------------------------------------------------------------------
module swm_cell import swm_pkg::*; (
	input  logic    clk,
	input  logic    advance,
	input  sample_t x,
	input  logic    full,
	input  logic    valid,
	input  age_t    len_m1,
	input  nb_t     left,
	input  nb_t     right,
	input  logic    del_in,
	output nb_t     nb_o,
	output logic    del_out
);

	sample_t val_q;
	age_t    age_q;
	sample_t val_d;
	age_t    age_d;
	logic    gt;
	logic    del_self;
	logic    prev_gt;

	assign gt       = !valid || (val_q > x);
	assign del_self = full && valid && (age_q == len_m1);
	assign del_out  = del_in || del_self;
	assign nb_o     = '{val: val_q, age: age_q, gt: gt};
	assign prev_gt  = del_in ? gt : left.gt;

	always_comb begin
		val_d = val_q;
		age_d = age_q + age_t'(1);
		if (!del_out) begin
			if (!gt) begin
				val_d = val_q;
				age_d = age_q + age_t'(1);
			end else if (!left.gt) begin
				val_d = x;
				age_d = '0;
			end else begin
				val_d = left.val;
				age_d = left.age + age_t'(1);
			end
		end else begin
			if (!right.gt) begin
				val_d = right.val;
				age_d = right.age + age_t'(1);
			end else if (!prev_gt) begin
				val_d = x;
				age_d = '0;
			end else if (del_in) begin
				val_d = val_q;
				age_d = age_q + age_t'(1);
			end else begin
				val_d = left.val;
				age_d = left.age + age_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			val_q <= val_d;
			age_q <= age_d;
		end
	end

endmodule

>>> src/swm_out_stage.sv
// ----------------------------------------------------------------------------
// swm_out_stage: median pick and output register
// Selects the middle slot of the sorted row and holds it until taken.
// ----------------------------------------------------------------------------
module swm_out_stage import swm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pend,
	input  logic [IDX_W-1:0] idx,
	input  sample_t    vals [WINDOW_MAX],
	output logic       take,
	output logic       out_valid,
	input  logic       out_ready,
	output sample_t    median
);

	logic    out_valid_q;
	sample_t median_q;

	assign take      = pend && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign median    = median_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			median_q <= vals[idx];
		end
	end

endmodule

>>> src/sliding_window_median_core.sv
// ----------------------------------------------------------------------------
// sliding_window_median_core: sliding window lower median filter
// Sorted row of cells with per-entry ages, window length register on APB.
// ----------------------------------------------------------------------------
// Takes one sample per clock while out_ready holds and gives the lower
// median of the last window_len samples (0 acts as 1, above 32 acts as
// 32) once the window is full; no beat comes out while it fills. The row
// of cells keeps the window sorted: each accepted sample drops the oldest
// entry and is inserted as the cells register, and the median is then
// registered in the output stage once it is free or out_ready is high.
// end_of_stream empties the window after its sample; any write of
// window_len (address 0) empties it as well.
module sliding_window_median_core import swm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sample_t              sample,
	input  logic                 end_of_stream,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sample_t              median
);

	logic [LEN_REG_W-1:0] window_len_q;
	logic [CNT_W-1:0]     fill_q;
	logic                 pend_s1;
	logic [CNT_W-1:0]     eff_len;
	logic [CNT_W-1:0]     fill_inc;
	age_t                 len_m1;
	logic [IDX_W-1:0]     med_idx;
	logic                 full;
	logic                 accept;
	logic                 produce;
	logic                 cfg_wr;
	logic                 take;

	nb_t                  nb_c  [WINDOW_MAX+2];
	logic                 del_c [WINDOW_MAX+1];
	sample_t              vals  [WINDOW_MAX];

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_WINDOW_LEN);

	always_comb begin
		prdata = '0;
		if (paddr[PADDR_W-1] == REG_WINDOW_LEN) begin
			prdata = PDATA_W'(window_len_q);
		end
	end

	always_comb begin
		if (window_len_q == '0) begin
			eff_len = CNT_W'(1);
		end else if (32'(window_len_q) > 32'(WINDOW_MAX)) begin
			eff_len = CNT_W'(WINDOW_MAX);
		end else begin
			eff_len = CNT_W'(window_len_q);
		end
	end

	assign len_m1   = AGE_W'(eff_len - CNT_W'(1));
	assign med_idx  = IDX_W'((eff_len - CNT_W'(1)) >> 1);
	assign full     = (fill_q == eff_len);
	assign fill_inc = fill_q + CNT_W'(1);
	assign produce  = full || (fill_inc == eff_len);
	assign in_ready = !pend_s1 || take;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= LEN_REG_W'(3);
			fill_q       <= '0;
			pend_s1      <= 1'b0;
		end else begin
			if (cfg_wr) begin
				window_len_q <= pwdata[LEN_REG_W-1:0];
				fill_q       <= '0;
			end else if (accept) begin
				if (end_of_stream) begin
					fill_q <= '0;
				end else if (!full) begin
					fill_q <= fill_inc;
				end
			end
			if (accept) begin
				pend_s1 <= produce;
			end else if (take) begin
				pend_s1 <= 1'b0;
			end
		end
	end

	assign nb_c[0]            = '{val: '0, age: '0, gt: 1'b0};
	assign nb_c[WINDOW_MAX+1] = '{val: '0, age: '0, gt: 1'b1};
	assign del_c[0]           = 1'b0;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic valid;
		assign valid   = (CNT_W'(i) < fill_q);
		assign vals[i] = nb_c[i+1].val;

		swm_cell u_cell (
			.clk     (clk),
			.advance (accept),
			.x       (sample),
			.full    (full),
			.valid   (valid),
			.len_m1  (len_m1),
			.left    (nb_c[i]),
			.right   (nb_c[i+2]),
			.del_in  (del_c[i]),
			.nb_o    (nb_c[i+1]),
			.del_out (del_c[i+1])
		);
	end

	swm_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.pend      (pend_s1),
		.idx       (med_idx),
		.vals      (vals),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.median    (median)
	);

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the sliding window median filter core
// Drives signed samples through the valid/ready input, sets the window length
// over APB, and checks every median beat against a behavioral window model.
// ----------------------------------------------------------------------------
module tb_top import swm_pkg::*; ();

	localparam logic [PADDR_W-1:0] ADDR_WINDOW_LEN = PADDR_W'(REG_WINDOW_LEN) << 2;
	localparam logic [PADDR_W-1:0] ADDR_UNMAPPED   = ADDR_WINDOW_LEN + PADDR_W'(4);
	localparam int                 RANDOM_PHASES   = 10;
	localparam int                 PHASE_SAMPLES   = 95;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	sample_t            sample;
	logic               end_of_stream;
	logic               out_valid;
	logic               out_ready;
	sample_t            median;

	sample_t              win_mem [WINDOW_MAX];
	int unsigned          win_fill;
	int unsigned          win_oldest;
	logic [LEN_REG_W-1:0] win_len_reg;
	sample_t              medians_due [$];

	int  errors;
	int  samples_sent;
	int  medians_checked;
	int  len_writes;
	int  stall_left;
	bit  tx_steady;
	bit  rx_steady;

	sliding_window_median_core uut (.*);

	always #10 clk = ~clk;

	function automatic int draw_wait(bit steady);
		if (steady)
			return 0;
		return $urandom_range(0, 6);
	endfunction

	function automatic int unsigned active_len();
		if (win_len_reg == 0)
			return 1;
		if (win_len_reg > WINDOW_MAX)
			return WINDOW_MAX;
		return win_len_reg;
	endfunction

	function automatic sample_t lower_median_of(int unsigned len);
		sample_t sorted [WINDOW_MAX];
		sample_t key;
		int      j;
		for (int i = 0; i < len; i++)
			sorted[i] = win_mem[i];
		for (int i = 1; i < len; i++) begin
			key = sorted[i];
			j = i;
			while (j > 0 && sorted[j-1] > key) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = key;
		end
		return sorted[(len - 1) / 2];
	endfunction

	function automatic void empty_window();
		win_fill = 0;
		win_oldest = 0;
	endfunction

	function automatic void predict_median(sample_t s, logic eos);
		int unsigned len;
		len = active_len();
		if (win_fill > len)
			empty_window();
		if (win_oldest >= len)
			win_oldest = 0;
		if (win_fill < len) begin
			win_mem[win_fill] = s;
			win_fill++;
			win_oldest = 0;
		end else begin
			win_mem[win_oldest] = s;
			win_oldest++;
			if (win_oldest >= len)
				win_oldest = 0;
		end
		if (win_fill == len)
			medians_due.insert(medians_due.size(), lower_median_of(len));
		if (eos)
			empty_window();
	endfunction

	function automatic sample_t rand_sample();
		case ($urandom_range(0, 9)) inside
			0:       return $urandom_range(0, 1) ? sample_t'(16'h7fff) : sample_t'(16'h8000);
			[1:3]:   return sample_t'(int'($urandom_range(0, 8)) - 4);
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [PDATA_W-1:0] got,
			logic [PDATA_W-1:0] want);
		errors++;
		$display("tb_top: mismatch %s: got 0x%h, want 0x%h (at %0t)", what, got, want,
			$realtime);
	endtask

	// call at a falling edge; returns at a falling edge with valid still high
	task automatic send_sample(sample_t s, logic eos);
		int gap;
		gap = draw_wait(tx_steady);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		sample        <= s;
		end_of_stream <= eos;
		do @(posedge clk); while (!in_ready);
		predict_median(s, eos);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (medians_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic read_apb(logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_apb(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		logic [PDATA_W-1:0] readback;
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr == ADDR_WINDOW_LEN) begin
			win_len_reg = data[LEN_REG_W-1:0];
			empty_window();
			len_writes++;
		end
		@(negedge clk);
		read_apb(ADDR_WINDOW_LEN, readback);
		if (readback !== PDATA_W'(win_len_reg))
			report_mismatch("window_len readback", readback, PDATA_W'(win_len_reg));
	endtask

	task automatic set_window_len(logic [LEN_REG_W-1:0] len);
		write_apb(ADDR_WINDOW_LEN, ($urandom & ~PDATA_W'(6'h3f)) | PDATA_W'(len));
	endtask

	task automatic test_default_length();
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd1, 1'b1);
	endtask

	task automatic test_short_windows();
		set_window_len(6'd1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7fff, 1'b0);
		set_window_len(6'd0);
		send_sample(16'sd5, 1'b0);
		send_sample(-16'sd5, 1'b1);
	endtask

	task automatic test_even_window();
		set_window_len(6'd2);
		send_sample(16'sd7, 1'b0);
		send_sample(16'sd7, 1'b0);
		send_sample(-16'sd3, 1'b0);
		send_sample(16'sd7, 1'b1);
	endtask

	task automatic test_stream_restart();
		set_window_len(6'd4);
		send_sample(16'sd1, 1'b0);
		send_sample(16'sd2, 1'b1);
		send_sample(16'sd3, 1'b0);
		send_sample(16'sd4, 1'b0);
		send_sample(16'sd5, 1'b0);
		send_sample(16'sd6, 1'b0);
	endtask

	task automatic test_register_access();
		set_window_len(6'd3);
		send_sample(16'sd10, 1'b0);
		send_sample(16'sd20, 1'b0);
		set_window_len(6'd3);
		send_sample(16'sd30, 1'b0);
		send_sample(16'sd40, 1'b0);
		send_sample(16'sd50, 1'b0);
		write_apb(ADDR_UNMAPPED, 32'h0000_0001);
		send_sample(16'sd60, 1'b1);
	endtask

	task automatic test_random_streams();
		logic [LEN_REG_W-1:0] len;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0:       len = 6'd32;
				1:       len = 6'd63;
				2:       len = 6'd0;
				3:       len = 6'd1;
				4:       len = 6'd2;
				5:       len = LEN_REG_W'($urandom_range(33, 63));
				6:       len = LEN_REG_W'($urandom_range(3, 31));
				7:       len = 6'd5;
				8:       len = 6'd17;
				default: len = LEN_REG_W'($urandom_range(0, 63));
			endcase
			set_window_len(len);
			for (int n = 0; n < PHASE_SAMPLES; n++) begin
				if (n % 16 == 0) begin
					tx_steady = ($urandom_range(0, 2) == 0);
					rx_steady = ($urandom_range(0, 2) == 0);
				end
				send_sample(rand_sample(), $urandom_range(0, 39) == 0);
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		stall_left = 0;
		out_ready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_median
		sample_t want;
		if (arst_n && out_valid && out_ready) begin
			if (medians_due.size() == 0) begin
				report_mismatch("median beat with none due", PDATA_W'(median), '0);
			end else begin
				want = medians_due.pop_front();
				if (median !== want)
					report_mismatch("median", PDATA_W'(median), PDATA_W'(want));
			end
			medians_checked++;
			stall_left = draw_wait(rx_steady);
		end
	end

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		in_valid      = 1'b0;
		sample        = '0;
		end_of_stream = 1'b0;
		errors          = 0;
		samples_sent    = 0;
		medians_checked = 0;
		len_writes      = 0;
		tx_steady       = 1'b0;
		rx_steady       = 1'b0;
		win_len_reg     = 6'd3;
		empty_window();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_default_length();
		test_short_windows();
		test_even_window();
		test_stream_restart();
		test_register_access();
		test_random_streams();

		wait_idle();
		repeat (10) @(negedge clk);
		$display("tb_top: %0d samples sent, %0d median beats checked, %0d length writes",
			samples_sent, medians_checked, len_writes);
		$display("tb_top: lengths 0 to 63 incl. oversized, restarts, duplicates, stalls");
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#4000000;
		$display("tb_top: timeout");
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

>>> sliding_window_median_core.f
src/swm_pkg.sv
src/swm_cell.sv
src/swm_out_stage.sv
src/sliding_window_median_core.sv
tb/tb_top.sv
